[design/wall_follow_roll_controller_top_assert.svh]
// assertion macros for the roll controller checker
`ifndef WALL_FOLLOW_ROLL_CONTROLLER_TOP_ASSERT_SVH
`define WALL_FOLLOW_ROLL_CONTROLLER_TOP_ASSERT_SVH

// same-cycle implication
`define WFRC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("wfrc assertion failed");

// next-cycle implication
`define WFRC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("wfrc assertion failed");

`endif

[design/wfrc_pkg.sv]
`default_nettype none

package wfrc_pkg;

  localparam int IN_DATA_W  = 80;
  localparam int OUT_DATA_W = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 10;

  localparam int GAIN_W   = 10;
  localparam int PULSE_W  = 7;
  localparam int BAND_W   = 9;
  localparam int DIST_W   = 9;
  localparam int DERR_W   = 10;
  localparam int WIDE_W   = 17;
  localparam int CMD_W    = 10;
  localparam int ROLL_W   = 8;

  localparam int MCAND_W   = 17;
  localparam int PROD_W    = 27;
  localparam int MUL_STEPS = GAIN_W;

  localparam int DIVISOR  = 100;
  localparam int DVD_W    = 15;
  localparam int QUO_W    = 8;
  localparam int REM_W    = 7;
  localparam int DIV_STEPS = DVD_W;

  localparam int DIST_LIMIT   = 300;
  localparam int JUMP_LIMIT   = 100;
  localparam int SETVEL_LIMIT = 200;
  localparam int PTERM_LIMIT  = 100;
  localparam int DTERM_LIMIT  = 40;
  localparam int ROLL_LIMIT   = 100;
  localparam int ACC_LOW      = -50;
  localparam int ACC_HIGH     = -20;
  localparam int VERR_LOW     = 15;
  localparam int VERR_HIGH    = 50;
  localparam int DAMP_SHIFT   = 9;

  localparam int SETVEL_SAT = (SETVEL_LIMIT + 1) * DIVISOR;
  localparam int PTERM_SAT  = (PTERM_LIMIT + 1) * DIVISOR;
  localparam int DTERM_SAT  = (DTERM_LIMIT + 1) * (1 << DAMP_SHIFT);
  localparam int DMAG_W     = 6;
  localparam int PMAG_W     = 7;

  localparam int POS_GAIN_RST  = 140;
  localparam int VEL_GAIN_RST  = 20;
  localparam int DAMP_GAIN_RST = 20;
  localparam int PULSE_RST     = 40;
  localparam int BAND_RST      = 25;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POS_GAIN  = 3'd0,
    CFG_VEL_GAIN  = 3'd1,
    CFG_DAMP_GAIN = 3'd2,
    CFG_PULSE     = 3'd3,
    CFG_NEAR_BAND = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic               start;
    logic [GAIN_W-1:0]  gain;
    logic [MCAND_W-1:0] mcand;
  } mul_req_t;

  typedef struct packed {
    logic              done;
    logic [PROD_W-1:0] product;
  } mul_rsp_t;

  typedef struct packed {
    logic             start;
    logic [DVD_W-1:0] dividend;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

[design/wfrc_mul.sv]
`default_nettype none

module wfrc_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wfrc_pkg::mul_req_t req_i,
  output wfrc_pkg::mul_rsp_t rsp_o
);
  import wfrc_pkg::*;

  localparam int CNT_W = $clog2(MUL_STEPS);

  logic              busy_q;
  logic              done_q;
  logic [CNT_W-1:0]  cnt_q;
  logic [GAIN_W-1:0] gain_q;
  logic [PROD_W-1:0] mcand_q;
  logic [PROD_W-1:0] acc_q;

  // gain bits shift out lsb first, one partial product per cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      cnt_q   <= '0;
      gain_q  <= '0;
      mcand_q <= '0;
      acc_q   <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q  <= 1'b1;
        cnt_q   <= '0;
        gain_q  <= req_i.gain;
        mcand_q <= PROD_W'(req_i.mcand);
        acc_q   <= '0;
      end else if (busy_q) begin
        if (gain_q[0]) begin
          acc_q <= acc_q + mcand_q;
        end
        gain_q  <= gain_q >> 1;
        mcand_q <= mcand_q << 1;
        cnt_q   <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(MUL_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done    = done_q;
  assign rsp_o.product = acc_q;

endmodule

`default_nettype wire

[design/wfrc_div.sv]
`default_nettype none

module wfrc_div (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  wfrc_pkg::div_req_t req_i,
  output wfrc_pkg::div_rsp_t rsp_o
);
  import wfrc_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS);

  logic             busy_q;
  logic             done_q;
  logic [CNT_W-1:0] cnt_q;
  logic [DVD_W-1:0] dvd_q;
  logic [DVD_W-1:0] quo_q;
  logic [REM_W-1:0] rem_q;
  logic [REM_W:0]   trial;
  logic [REM_W:0]   trial_sub;
  logic             fits;

  // restoring division by a constant, one quotient bit per cycle
  always_comb begin
    trial     = {rem_q, dvd_q[DVD_W-1]};
    fits      = (trial >= (REM_W + 1)'(DIVISOR));
    trial_sub = trial - (REM_W + 1)'(DIVISOR);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      dvd_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
        dvd_q  <= req_i.dividend;
        quo_q  <= '0;
        rem_q  <= '0;
      end else if (busy_q) begin
        rem_q <= fits ? trial_sub[REM_W-1:0] : trial[REM_W-1:0];
        quo_q <= {quo_q[DVD_W-2:0], fits};
        dvd_q <= dvd_q << 1;
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNT_W'(DIV_STEPS - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q[QUO_W-1:0];

endmodule

`default_nettype wire

[design/wall_follow_roll_controller_top.sv]
// Wall-following roll controller.
// Input stream: one transfer per control tick. s_axis_tuser carries the mode
// switch; s_axis_tdata carries wall distance, previous distance, lateral
// velocity, current and previous acceleration (16 bits each, lowest first).
// Output stream: one transfer per input. m_axis_tdata is the signed roll
// command (-100..100), m_axis_tuser is the mode-active flag.
// Config channel: cfg_valid_i/cfg_ready_o with a register index and data;
// ready is always high, unknown indexes are dropped. Write only while idle.
// A new input is taken in the cycle after the result is placed in the output
// register, so the block works on one input at a time. Each item with the mode
// switch on uses the shared shift-add multiplier (10 steps, three products per
// item) and the serial divide-by-100 unit (15 steps, up to two per item; a P
// term that saturates skips its divide). Reset clears the engaged flag, the
// target distance and the output valid, and loads the default gains. The
// output register holds a result until it is taken; while it is full a
// finished item waits, and no input is accepted until that item is written
// into it.
`default_nettype none

module wall_follow_roll_controller_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // wall_distance, previous_distance, lateral_velocity, accel_now, accel_before
  input  logic [wfrc_pkg::IN_DATA_W-1:0] s_axis_tdata,
  // mode_switch
  input  logic                           s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // roll_command
  output logic [wfrc_pkg::OUT_DATA_W-1:0] m_axis_tdata,
  // mode_active
  output logic                           m_axis_tuser,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [wfrc_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [wfrc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import wfrc_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_COND,
    ST_ERR,
    ST_POS_GO,
    ST_POS_MUL,
    ST_POS_DIV,
    ST_VERR,
    ST_VEL_GO,
    ST_VEL_MUL,
    ST_VEL_DIV,
    ST_DAMP_GO,
    ST_DAMP_MUL,
    ST_SUM,
    ST_EMIT
  } state_e;

  state_e state_q;

  logic [GAIN_W-1:0]  pos_gain_q;
  logic [GAIN_W-1:0]  vel_gain_q;
  logic [GAIN_W-1:0]  damp_gain_q;
  logic [PULSE_W-1:0] pulse_q;
  logic [BAND_W-1:0]  band_q;

  logic               sw_q;
  logic [15:0]        dist_q;
  logic [15:0]        prev_q;
  logic signed [15:0] vel_q;
  logic signed [15:0] acc_now_q;
  logic signed [15:0] acc_bef_q;

  logic               engaged_q;
  logic [DIST_W-1:0]  target_q;
  logic [DIST_W-1:0]  d_q;
  logic signed [DERR_W-1:0] derr_q;
  logic signed [WIDE_W-1:0] asum_q;
  logic signed [WIDE_W-1:0] verr_q;
  logic [QUO_W-1:0]   setmag_q;
  logic [PMAG_W-1:0]  pmag_q;
  logic [DMAG_W-1:0]  dmag_q;
  logic [ROLL_W-1:0]  res_cmd_q;
  logic               res_active_q;

  logic               out_valid_q;
  logic [ROLL_W-1:0]  out_cmd_q;
  logic               out_active_q;

  mul_req_t mul_req;
  mul_rsp_t mul_rsp;
  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [15:0]              d_clip;
  logic [15:0]              d_nz;
  logic signed [16:0]       jump_diff;
  logic [15:0]              d_sel;
  logic signed [DERR_W-1:0] derr_d;
  logic [DERR_W-1:0]        derr_abs;
  logic signed [WIDE_W-1:0] asum_d;
  logic [WIDE_W-1:0]        asum_abs;
  logic signed [WIDE_W-1:0] setvel;
  logic signed [WIDE_W-1:0] verr_d;
  logic [WIDE_W-1:0]        verr_abs;
  logic signed [CMD_W-1:0]  pterm;
  logic signed [CMD_W-1:0]  dterm;
  logic signed [CMD_W-1:0]  pulse_s;
  logic signed [CMD_W-1:0]  cmd_base;
  logic signed [CMD_W-1:0]  cmd_sum;
  logic                     near;
  logic                     acc_in_band;
  logic                     verr_pos;
  logic                     verr_neg;
  logic [ROLL_W-1:0]        cmd_clip;

  always_comb begin
    d_clip    = (dist_q > 16'(DIST_LIMIT)) ? 16'(DIST_LIMIT) : dist_q;
    d_nz      = (d_clip == '0) ? 16'd1 : d_clip;
    jump_diff = $signed({1'b0, d_nz}) - $signed({1'b0, prev_q});
    d_sel     = (jump_diff > 17'sd100) ? prev_q : d_nz;

    derr_d   = $signed({1'b0, target_q}) - $signed({1'b0, d_q});
    derr_abs = derr_q[DERR_W-1] ? DERR_W'(-derr_q) : DERR_W'(derr_q);
    asum_d   = $signed({acc_now_q[15], acc_now_q}) + $signed({acc_bef_q[15], acc_bef_q});
    asum_abs = asum_q[WIDE_W-1] ? WIDE_W'(-asum_q) : WIDE_W'(asum_q);

    setvel   = derr_q[DERR_W-1] ? -$signed({9'b0, setmag_q}) : $signed({9'b0, setmag_q});
    verr_d   = $signed({vel_q[15], vel_q}) - setvel;
    verr_abs = verr_q[WIDE_W-1] ? WIDE_W'(-verr_q) : WIDE_W'(verr_q);

    pterm    = verr_q[WIDE_W-1] ? -$signed({3'b0, pmag_q}) : $signed({3'b0, pmag_q});
    dterm    = asum_q[WIDE_W-1] ? -$signed({4'b0, dmag_q}) : $signed({4'b0, dmag_q});
    pulse_s  = $signed({3'b0, pulse_q});
    cmd_base = pterm - dterm;

    near        = (derr_abs <= {1'b0, band_q});
    acc_in_band = (asum_q >= WIDE_W'(ACC_LOW)) && (asum_q <= WIDE_W'(ACC_HIGH));
    verr_pos    = (verr_q >= WIDE_W'(VERR_LOW)) && (verr_q <= WIDE_W'(VERR_HIGH));
    verr_neg    = (verr_q >= WIDE_W'(-VERR_HIGH)) && (verr_q <= WIDE_W'(-VERR_LOW));

    cmd_sum = cmd_base;
    if (near && acc_in_band) begin
      if (verr_pos) begin
        cmd_sum = cmd_base - pulse_s;
      end else if (verr_neg) begin
        cmd_sum = cmd_base + pulse_s;
      end
    end

    if (cmd_sum > CMD_W'(ROLL_LIMIT)) begin
      cmd_clip = ROLL_W'(ROLL_LIMIT);
    end else if (cmd_sum < CMD_W'(-ROLL_LIMIT)) begin
      cmd_clip = ROLL_W'(-ROLL_LIMIT);
    end else begin
      cmd_clip = cmd_sum[ROLL_W-1:0];
    end
  end

  // operand selection for the shared multiplier and divider
  always_comb begin
    mul_req.start = 1'b0;
    mul_req.gain  = pos_gain_q;
    mul_req.mcand = MCAND_W'(derr_abs);
    div_req.start    = 1'b0;
    div_req.dividend = mul_rsp.product[DVD_W-1:0];
    unique case (state_q)
      ST_POS_GO: begin
        mul_req.start = 1'b1;
      end
      ST_VEL_GO: begin
        mul_req.start = 1'b1;
        mul_req.gain  = vel_gain_q;
        mul_req.mcand = verr_abs;
      end
      ST_DAMP_GO: begin
        mul_req.start = 1'b1;
        mul_req.gain  = damp_gain_q;
        mul_req.mcand = asum_abs;
      end
      ST_POS_MUL: begin
        div_req.start = mul_rsp.done && (mul_rsp.product < PROD_W'(SETVEL_SAT));
      end
      ST_VEL_MUL: begin
        div_req.start = mul_rsp.done && (mul_rsp.product < PROD_W'(PTERM_SAT));
      end
      default: begin
      end
    endcase
  end

  wfrc_mul u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (mul_req),
    .rsp_o  (mul_rsp)
  );

  wfrc_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_gain_q  <= GAIN_W'(POS_GAIN_RST);
      vel_gain_q  <= GAIN_W'(VEL_GAIN_RST);
      damp_gain_q <= GAIN_W'(DAMP_GAIN_RST);
      pulse_q     <= PULSE_W'(PULSE_RST);
      band_q      <= BAND_W'(BAND_RST);
    end else if (cfg_valid_i) begin
      unique case (cfg_idx_e'(cfg_index_i))
        CFG_POS_GAIN:  pos_gain_q  <= cfg_data_i;
        CFG_VEL_GAIN:  vel_gain_q  <= cfg_data_i;
        CFG_DAMP_GAIN: damp_gain_q <= cfg_data_i;
        CFG_PULSE:     pulse_q     <= cfg_data_i[PULSE_W-1:0];
        CFG_NEAR_BAND: band_q      <= cfg_data_i[BAND_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      engaged_q    <= 1'b0;
      target_q     <= '0;
      sw_q         <= 1'b0;
      dist_q       <= '0;
      prev_q       <= '0;
      vel_q        <= '0;
      acc_now_q    <= '0;
      acc_bef_q    <= '0;
      d_q          <= '0;
      derr_q       <= '0;
      asum_q       <= '0;
      verr_q       <= '0;
      setmag_q     <= '0;
      pmag_q       <= '0;
      dmag_q       <= '0;
      res_cmd_q    <= '0;
      res_active_q <= 1'b0;
      out_valid_q  <= 1'b0;
      out_cmd_q    <= '0;
      out_active_q <= 1'b0;
    end else begin
      if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (s_axis_tvalid) begin
            sw_q      <= s_axis_tuser;
            dist_q    <= s_axis_tdata[15:0];
            prev_q    <= s_axis_tdata[31:16];
            vel_q     <= s_axis_tdata[47:32];
            acc_now_q <= s_axis_tdata[63:48];
            acc_bef_q <= s_axis_tdata[79:64];
            state_q   <= ST_COND;
          end
        end
        ST_COND: begin
          if (!sw_q) begin
            engaged_q    <= 1'b0;
            res_cmd_q    <= '0;
            res_active_q <= 1'b0;
            state_q      <= ST_EMIT;
          end else begin
            d_q <= d_sel[DIST_W-1:0];
            if (!engaged_q) begin
              engaged_q <= 1'b1;
              target_q  <= d_sel[DIST_W-1:0];
            end
            state_q <= ST_ERR;
          end
        end
        ST_ERR: begin
          derr_q  <= derr_d;
          asum_q  <= asum_d;
          state_q <= ST_POS_GO;
        end
        ST_POS_GO: begin
          state_q <= ST_POS_MUL;
        end
        ST_POS_MUL: begin
          if (mul_rsp.done) begin
            if (mul_rsp.product >= PROD_W'(SETVEL_SAT)) begin
              setmag_q <= QUO_W'(SETVEL_LIMIT);
              state_q  <= ST_VERR;
            end else begin
              state_q <= ST_POS_DIV;
            end
          end
        end
        ST_POS_DIV: begin
          if (div_rsp.done) begin
            setmag_q <= div_rsp.quotient;
            state_q  <= ST_VERR;
          end
        end
        ST_VERR: begin
          verr_q  <= verr_d;
          state_q <= ST_VEL_GO;
        end
        ST_VEL_GO: begin
          state_q <= ST_VEL_MUL;
        end
        ST_VEL_MUL: begin
          if (mul_rsp.done) begin
            if (mul_rsp.product >= PROD_W'(PTERM_SAT)) begin
              pmag_q  <= PMAG_W'(PTERM_LIMIT);
              state_q <= ST_DAMP_GO;
            end else begin
              state_q <= ST_VEL_DIV;
            end
          end
        end
        ST_VEL_DIV: begin
          if (div_rsp.done) begin
            pmag_q  <= div_rsp.quotient[PMAG_W-1:0];
            state_q <= ST_DAMP_GO;
          end
        end
        ST_DAMP_GO: begin
          state_q <= ST_DAMP_MUL;
        end
        ST_DAMP_MUL: begin
          if (mul_rsp.done) begin
            if (mul_rsp.product >= PROD_W'(DTERM_SAT)) begin
              dmag_q <= DMAG_W'(DTERM_LIMIT);
            end else begin
              dmag_q <= mul_rsp.product[DAMP_SHIFT+DMAG_W-1:DAMP_SHIFT];
            end
            state_q <= ST_SUM;
          end
        end
        ST_SUM: begin
          res_cmd_q    <= cmd_clip;
          res_active_q <= 1'b1;
          state_q      <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!out_valid_q || m_axis_tready) begin
            out_valid_q  <= 1'b1;
            out_cmd_q    <= res_cmd_q;
            out_active_q <= res_active_q;
            state_q      <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_cmd_q;
  assign m_axis_tuser  = out_active_q;
  assign cfg_ready_o   = 1'b1;

endmodule

`default_nettype wire

[design/wfrc_checker.sv]
`default_nettype none
`include "wall_follow_roll_controller_top_assert.svh"

module wfrc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic       m_axis_tuser
);

  // command stays inside the roll limit
  `WFRC_ASSERT_IMP(a_roll_range, m_axis_tvalid, ($signed(m_axis_tdata) >= -8'sd100) && ($signed(m_axis_tdata) <= 8'sd100))

  // mode off always gives a zero command
  `WFRC_ASSERT_IMP(a_off_zero, m_axis_tvalid && !m_axis_tuser, m_axis_tdata == 8'd0)

  // one item at a time: busy right after an input transfer
  `WFRC_ASSERT_NXT(a_busy_after_in, s_axis_tvalid && s_axis_tready, !s_axis_tready)

  // stalled result holds
  `WFRC_ASSERT_NXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))

endmodule

bind wall_follow_roll_controller_top wfrc_checker u_wfrc_checker (.*);

`default_nettype wire
